// ----- design/lleu_pkg.sv -----
// Shared types, codes and mask helpers for the LTL lasso evaluator.
// No dependencies; the queue, front, back and top design files import this package.
`timescale 1ns / 1ps

package lleu_pkg;

  localparam int MAX_NODES_DEF     = 64;
  localparam int MAX_POSITIONS_DEF = 64;
  localparam int QUEUE_DEPTH       = 2;
  localparam int MASK_W            = 64;
  localparam int POS_W             = 7;
  localparam int LOOP_W            = 6;
  localparam int IDX_W             = 6;
  localparam int CFG_IDX_W         = 2;

  typedef logic [MASK_W-1:0] mask_t;

  typedef enum logic [3:0] {
    OP_ATOM       = 4'd0,
    OP_NOT        = 4'd1,
    OP_AND        = 4'd2,
    OP_OR         = 4'd3,
    OP_IMPLIES    = 4'd4,
    OP_IFF        = 4'd5,
    OP_NEXT       = 4'd6,
    OP_EVENTUALLY = 4'd7,
    OP_GLOBALLY   = 4'd8,
    OP_UNTIL      = 4'd9,
    OP_WEAK_UNTIL = 4'd10,
    OP_RELEASE    = 4'd11
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSITIONS = 2'd0,
    CFG_LOOP_BACK = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_ITER,
    BK_WRITE
  } back_state_t;

  // classified node command handed from front to back
  typedef struct packed {
    op_t   op;
    mask_t atom;
    logic  last;
    logic  zero_a;
    logic  zero_b;
    logic  bad;
    logic  store;
  } cmd_t;

  function automatic mask_t succ_shift(mask_t m, logic [POS_W-1:0] n,
                                       logic [LOOP_W-1:0] lp, mask_t all);
    mask_t r;
    r = (m >> 1) & (all >> 1);
    r = r | (mask_t'(m[lp]) << (n - 7'd1));
    return r;
  endfunction

endpackage

// ----- design/lleu_in_if.sv -----
// Input channel of the LTL lasso evaluator: one formula node per item.
// Standalone; widths follow the node item fields.
`timescale 1ns / 1ps

interface lleu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [5:0]  left_index;
  logic [5:0]  right_index;
  logic [63:0] atom_bits;
  logic        last_node;

  modport source (output valid, operation, left_index, right_index, atom_bits,
                  last_node, input ready);
  modport sink (input valid, operation, left_index, right_index, atom_bits,
                last_node, output ready);
endinterface

// ----- design/lleu_out_if.sv -----
// Result channel of the LTL lasso evaluator: one node mask per item.
// Standalone; widths follow the result item fields.
`timescale 1ns / 1ps

interface lleu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] node_truth_mask;
  logic        holds_at_start;
  logic        formula_end;
  logic        bad_reference;

  modport source (output valid, node_truth_mask, holds_at_start, formula_end,
                  bad_reference, input ready);
  modport sink (input valid, node_truth_mask, holds_at_start, formula_end,
                bad_reference, output ready);
endinterface

// ----- design/lleu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lleu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lleu_queue.sv -----
// Short FIFO between the front (classify) and back (evaluate) parts.
// Depends on lleu_pkg for the default depth.
`timescale 1ns / 1ps

module lleu_queue
  import lleu_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rptr_r];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

// ----- design/lleu_front.sv -----
// Front part: accepts node items, numbers them, checks child references.
// Depends on lleu_pkg and lleu_in_if.
`timescale 1ns / 1ps

module lleu_front
  import lleu_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int AW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  lleu_in_if.sink       in_chan,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd,
  output logic [AW-1:0] q_wa,
  output logic [AW-1:0] q_ra,
  output logic [AW-1:0] q_rb
);

  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int IW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int CMPW = ((CW > IDX_W) ? CW : IDX_W) + 1;

  logic [CW-1:0] cnt_r, cnt_nxt;
  op_t           op;
  logic          uses_a, uses_b, bad_a, bad_b, store;
  logic [IW-1:0] li_x, ri_x;

  assign op = op_t'(in_chan.operation);

  always_comb begin
    uses_a = 1'b0;
    uses_b = 1'b0;
    case (op)
      OP_NOT, OP_NEXT, OP_EVENTUALLY, OP_GLOBALLY: begin
        uses_a = 1'b1;
      end
      OP_AND, OP_OR, OP_IMPLIES, OP_IFF, OP_UNTIL, OP_WEAK_UNTIL, OP_RELEASE: begin
        uses_a = 1'b1;
        uses_b = 1'b1;
      end
      default: begin
        uses_a = 1'b0;
      end
    endcase
  end

  assign bad_a = uses_a && (CMPW'(in_chan.left_index) >= CMPW'(cnt_r));
  assign bad_b = uses_b && (CMPW'(in_chan.right_index) >= CMPW'(cnt_r));
  assign store = (cnt_r != CW'(MAX_NODES));

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_chan.last_node) begin
        cnt_nxt = '0;
      end else if (store) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign li_x = IW'(in_chan.left_index);
  assign ri_x = IW'(in_chan.right_index);

  always_comb begin
    q_cmd.op     = op;
    q_cmd.atom   = in_chan.atom_bits;
    q_cmd.last   = in_chan.last_node;
    q_cmd.zero_a = bad_a || !uses_a;
    q_cmd.zero_b = bad_b || !uses_b;
    q_cmd.bad    = bad_a || bad_b;
    q_cmd.store  = store;
  end

  assign q_wa = cnt_r[AW-1:0];
  assign q_ra = li_x[AW-1:0];
  assign q_rb = ri_x[AW-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_NODES)) else $error("node number beyond store size");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_chan.last_node) |=> (cnt_r == '0))
    else $error("node number not cleared after root");

endmodule

// ----- design/lleu_back.sv -----
// Back part: reads child masks, evaluates the node, iterates the temporal
// fixed point, stores the mask and drives the result register.
// Depends on lleu_pkg, lleu_out_if and lleu_ram.
`timescale 1ns / 1ps

module lleu_back
  import lleu_pkg::*;
#(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int AW            = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  input  logic                 q_empty,
  input  cmd_t                 q_cmd,
  input  logic [AW-1:0]        q_wa,
  input  logic [AW-1:0]        q_ra,
  input  logic [AW-1:0]        q_rb,
  output logic                 q_pop,
  lleu_out_if.source           out_chan
);

  localparam int RW = $clog2(MAX_POSITIONS + 1);
  localparam logic [POS_W-1:0] MAXP = POS_W'(MAX_POSITIONS);

  back_state_t       state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [LOOP_W-1:0] loop_r, loop_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [AW-1:0]     wa_r, wa_nxt;
  mask_t             a_r, a_nxt, b_r, b_nxt, val_r, val_nxt;
  logic [RW-1:0]     round_r, round_nxt;
  logic              out_valid_r, out_valid_nxt;
  mask_t             out_mask_r, out_mask_nxt;
  logic              out_last_r, out_last_nxt, out_bad_r, out_bad_nxt;

  logic [POS_W-1:0]  n_eff;
  logic [LOOP_W-1:0] loop_eff;
  mask_t             all_mask;
  mask_t             rd_a, rd_b, a_in, b_in, s_cur, nx, s_a;
  logic              ram_we;

  always_comb begin
    if (pos_r == '0) begin
      n_eff = POS_W'(1);
    end else if (pos_r > MAXP) begin
      n_eff = MAXP;
    end else begin
      n_eff = pos_r;
    end
  end

  assign loop_eff = (POS_W'(loop_r) >= n_eff) ? LOOP_W'(n_eff - 7'd1) : loop_r;
  assign all_mask = ~({MASK_W{1'b1}} << n_eff);

  always_comb begin
    pos_nxt  = pos_r;
    loop_nxt = loop_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POSITIONS: pos_nxt  = cfg_data;
        CFG_LOOP_BACK: loop_nxt = cfg_data[LOOP_W-1:0];
        default: begin
          pos_nxt = pos_r;
        end
      endcase
    end
  end

  lleu_ram #(.WIDTH(MASK_W), .DEPTH(MAX_NODES), .AW(AW)) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wa_r),
    .wdata (val_r),
    .re    (q_pop),
    .raddr (q_ra),
    .rdata (rd_a)
  );

  lleu_ram #(.WIDTH(MASK_W), .DEPTH(MAX_NODES), .AW(AW)) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wa_r),
    .wdata (val_r),
    .re    (q_pop),
    .raddr (q_rb),
    .rdata (rd_b)
  );

  assign a_in  = cmd_r.zero_a ? '0 : rd_a;
  assign b_in  = cmd_r.zero_b ? '0 : rd_b;
  assign s_a   = succ_shift(a_in, n_eff, loop_eff, all_mask);
  assign s_cur = succ_shift(val_r, n_eff, loop_eff, all_mask);

  always_comb begin
    case (cmd_r.op)
      OP_EVENTUALLY: nx = a_r | s_cur;
      OP_GLOBALLY:   nx = a_r & s_cur;
      OP_RELEASE:    nx = b_r & (a_r | s_cur);
      default:       nx = b_r | (a_r & s_cur);
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    wa_nxt        = wa_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    val_nxt       = val_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          wa_nxt    = q_wa;
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        a_nxt     = a_in;
        b_nxt     = b_in;
        round_nxt = '0;
        state_nxt = BK_WRITE;
        case (cmd_r.op)
          OP_ATOM:    val_nxt = cmd_r.atom & all_mask;
          OP_NOT:     val_nxt = ~a_in & all_mask;
          OP_AND:     val_nxt = a_in & b_in;
          OP_OR:      val_nxt = a_in | b_in;
          OP_IMPLIES: val_nxt = (~a_in & all_mask) | b_in;
          OP_IFF:     val_nxt = ~(a_in ^ b_in) & all_mask;
          OP_NEXT:    val_nxt = s_a;
          OP_EVENTUALLY, OP_UNTIL: begin
            val_nxt   = '0;
            state_nxt = BK_ITER;
          end
          OP_GLOBALLY, OP_WEAK_UNTIL, OP_RELEASE: begin
            val_nxt   = all_mask;
            state_nxt = BK_ITER;
          end
          default:    val_nxt = '0;
        endcase
      end
      BK_ITER: begin
        if (nx == val_r) begin
          state_nxt = BK_WRITE;
        end else begin
          val_nxt = nx;
          if (round_r == RW'(n_eff)) begin
            state_nxt = BK_WRITE;
          end else begin
            round_nxt = round_r + 1'b1;
          end
        end
      end
      BK_WRITE: begin
        if (!out_valid_r || out_chan.ready) begin
          ram_we        = cmd_r.store;
          out_valid_nxt = 1'b1;
          out_mask_nxt  = val_r;
          out_last_nxt  = cmd_r.last;
          out_bad_nxt   = cmd_r.bad;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= POS_W'(64);
      loop_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      loop_r      <= loop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    wa_r       <= wa_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    val_r      <= val_nxt;
    round_r    <= round_nxt;
    out_mask_r <= out_mask_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.node_truth_mask = out_mask_r;
  assign out_chan.holds_at_start  = out_mask_r[0];
  assign out_chan.formula_end     = out_last_r;
  assign out_chan.bad_reference   = out_bad_r;

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_ITER) |-> (round_r <= RW'(n_eff)))
    else $error("fixed point ran past its round limit");

  a_mask_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_mask_r & ~all_mask) == '0))
    else $error("result mask has bits beyond the word");

endmodule

// ----- design/ltl_lasso_bitmask_evaluator_unit.sv -----
// Boolean, atom and next nodes are evaluated without iteration; temporal nodes
// iterate fixed-point rounds until the mask settles, at most positions+1 rounds.
// Nodes are evaluated one at a time by the single shared fixed-point round unit,
// while the queue lets the front accept further nodes.
// Reset (synchronous, rst_n low): queue empty, node number 0, positions 64,
// loop-back 0; the node store is not cleared.
`timescale 1ns / 1ps

module ltl_lasso_bitmask_evaluator_unit
  import lleu_pkg::*;
#(
  parameter int MAX_NODES     = MAX_NODES_DEF,
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lleu_in_if.sink              in_chan,
  lleu_out_if.source           out_chan,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int QW = $bits(cmd_t) + 3 * AW;

  logic          q_push, q_full, q_pop, q_empty;
  cmd_t          f_cmd, b_cmd;
  logic [AW-1:0] f_wa, f_ra, f_rb, b_wa, b_ra, b_rb;
  logic [QW-1:0] q_din, q_dout;

  assign cfg_ready = 1'b1;

  lleu_front #(.MAX_NODES(MAX_NODES), .AW(AW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (f_cmd),
    .q_wa    (f_wa),
    .q_ra    (f_ra),
    .q_rb    (f_rb)
  );

  assign q_din = {f_cmd, f_wa, f_ra, f_rb};

  lleu_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign {b_cmd, b_wa, b_ra, b_rb} = q_dout;

  lleu_back #(
    .MAX_NODES     (MAX_NODES),
    .MAX_POSITIONS (MAX_POSITIONS),
    .AW            (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_cmd     (b_cmd),
    .q_wa      (b_wa),
    .q_ra      (b_ra),
    .q_rb      (b_rb),
    .q_pop     (q_pop),
    .out_chan  (out_chan)
  );

endmodule

// ----- tb/lleu_node_checker.sv -----
// Checker for the LTL lasso evaluator: watches the node, result and register channels,
// predicts each node's truth mask and compares it with the block's results.
// Depends on lleu_pkg and the lleu_in_if / lleu_out_if interfaces.
`timescale 1ns / 1ps

module lleu_node_checker
  import lleu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  lleu_in_if                   in_mon,
  lleu_out_if                  out_mon,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   awaited
);

  typedef struct {
    mask_t truth;
    logic  start;
    logic  fin;
    logic  bad;
  } node_result_t;

  mask_t             node_store [MAX_NODES_DEF];
  int                node_count;
  logic [POS_W-1:0]  positions;
  logic [LOOP_W-1:0] loop_to;
  node_result_t      expected_nodes [$];
  node_result_t      head;
  int                fails = 0;
  int                backlog = 0;

  assign mismatches = fails;
  assign awaited    = backlog;

  function automatic mask_t word_mask(int n);
    return (n >= MASK_W) ? '1 : ((mask_t'(1) << n) - mask_t'(1));
  endfunction

  function automatic mask_t succ_of(mask_t m, int n, int lp);
    mask_t r;
    r = (m >> 1) & (word_mask(n) >> 1);
    if (m[lp]) r = r | (mask_t'(1) << (n - 1));
    return r;
  endfunction

  function automatic mask_t fixpoint_of(logic [3:0] kind, mask_t a, mask_t b, int n, int lp);
    mask_t cur;
    mask_t s;
    mask_t nx;
    cur = (kind == OP_EVENTUALLY || kind == OP_UNTIL) ? '0 : word_mask(n);
    for (int r = 0; r <= n; r++) begin
      s = succ_of(cur, n, lp);
      case (kind)
        OP_EVENTUALLY: nx = a | s;
        OP_GLOBALLY:   nx = a & s;
        OP_RELEASE:    nx = b & (a | s);
        default:       nx = b | (a & s);
      endcase
      if (nx == cur) break;
      cur = nx;
    end
    return cur;
  endfunction

  function automatic mask_t fetch_child(logic [IDX_W-1:0] idx, inout logic bad);
    if (int'(idx) >= node_count) begin
      bad = 1'b1;
      return '0;
    end
    return node_store[idx];
  endfunction

  function automatic node_result_t eval_node(logic [3:0] op, logic [IDX_W-1:0] li,
                                             logic [IDX_W-1:0] ri, mask_t atom,
                                             logic last);
    node_result_t res;
    int    n;
    int    lp;
    mask_t full;
    mask_t a;
    mask_t b;
    mask_t v;
    logic  bad;
    n = (positions == 0) ? 1 : (positions > MAX_POSITIONS_DEF) ? MAX_POSITIONS_DEF
                                                               : int'(positions);
    lp = (int'(loop_to) >= n) ? n - 1 : int'(loop_to);
    full = word_mask(n);
    a = '0;
    b = '0;
    bad = 1'b0;
    if (op >= OP_NOT && op <= OP_RELEASE) a = fetch_child(li, bad);
    if ((op >= OP_AND && op <= OP_IFF) || (op >= OP_UNTIL && op <= OP_RELEASE))
      b = fetch_child(ri, bad);
    case (op)
      OP_ATOM:    v = atom & full;
      OP_NOT:     v = ~a & full;
      OP_AND:     v = a & b;
      OP_OR:      v = a | b;
      OP_IMPLIES: v = (~a & full) | b;
      OP_IFF:     v = ~(a ^ b) & full;
      OP_NEXT:    v = succ_of(a, n, lp);
      OP_EVENTUALLY, OP_GLOBALLY, OP_UNTIL, OP_WEAK_UNTIL, OP_RELEASE:
        v = fixpoint_of(op, a, b, n, lp);
      default:    v = '0;
    endcase
    if (node_count < MAX_NODES_DEF) begin
      node_store[node_count] = v;
      node_count++;
    end
    if (last) node_count = 0;
    res.truth = v;
    res.start = v[0];
    res.fin   = last;
    res.bad   = bad;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      node_count = 0;
      positions  = POS_W'(MAX_POSITIONS_DEF);
      loop_to    = '0;
      expected_nodes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POSITIONS: positions = cfg_data;
          CFG_LOOP_BACK: loop_to = cfg_data[LOOP_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_nodes = {expected_nodes, eval_node(in_mon.operation, in_mon.left_index,
                                                    in_mon.right_index, in_mon.atom_bits,
                                                    in_mon.last_node)};
      if (out_mon.valid && out_mon.ready) begin
        if (expected_nodes.size() == 0) begin
          $error("unexpected result item: mask %h", out_mon.node_truth_mask);
          fails++;
        end else begin
          head = expected_nodes.pop_front();
          if (out_mon.node_truth_mask !== head.truth) begin
            $error("node_truth_mask: expected %h, got %h", head.truth,
                   out_mon.node_truth_mask);
            fails++;
          end
          if (out_mon.holds_at_start !== head.start) begin
            $error("holds_at_start: expected %b, got %b", head.start,
                   out_mon.holds_at_start);
            fails++;
          end
          if (out_mon.formula_end !== head.fin) begin
            $error("formula_end: expected %b, got %b", head.fin, out_mon.formula_end);
            fails++;
          end
          if (out_mon.bad_reference !== head.bad) begin
            $error("bad_reference: expected %b, got %b", head.bad, out_mon.bad_reference);
            fails++;
          end
        end
      end
    end
    backlog = expected_nodes.size();
  end

endmodule

// ----- tb/tb_ltl_lasso_bitmask_evaluator_unit.sv -----
// Top of the LTL lasso evaluator testbench: clock, reset, node and register stimulus,
// random receiver stalls and the verdict. Depends on lleu_pkg, both channel
// interfaces, the evaluator and lleu_node_checker.
`timescale 1ns / 1ps

module tb_ltl_lasso_bitmask_evaluator_unit;
  import lleu_pkg::*;

  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 100;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [POS_W-1:0]     cfg_data;
  int                   send_idle;
  int                   stall_pct;
  int                   mismatches;
  int                   awaited;

  logic [POS_W-1:0]  phase_pos  [PHASES] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd7, 7'd20,
                                             7'd64, 7'd33};
  logic [LOOP_W-1:0] phase_loop [PHASES] = '{6'd0, 6'd63, 6'd5, 6'd0, 6'd3, 6'd45,
                                             6'd17, 6'd32};
  int                idle_send  [4] = '{0, 81, 0, 28};
  int                idle_stall [4] = '{0, 0, 81, 28};

  lleu_in_if  node_chan ();
  lleu_out_if mask_chan ();

  ltl_lasso_bitmask_evaluator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (node_chan),
    .out_chan  (mask_chan),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lleu_node_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (node_chan),
    .out_mon    (mask_chan),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    mask_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      mask_chan.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_node(logic [3:0] op, logic [IDX_W-1:0] li, logic [IDX_W-1:0] ri,
                           mask_t atom, logic last);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      node_chan.valid = 1'b0;
      @(negedge clk);
    end
    node_chan.valid       = 1'b1;
    node_chan.operation   = op;
    node_chan.left_index  = li;
    node_chan.right_index = ri;
    node_chan.atom_bits   = atom;
    node_chan.last_node   = last;
    do @(posedge clk); while (!node_chan.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [POS_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    node_chan.valid = 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic send_formula(int size);
    logic [3:0]       op;
    logic [IDX_W-1:0] li;
    logic [IDX_W-1:0] ri;
    mask_t            atom;
    int               reach;
    for (int k = 0; k < size; k++) begin
      reach = (k > MAX_NODES_DEF) ? MAX_NODES_DEF : k;
      if (k == 0 || $urandom_range(3) == 0) op = OP_ATOM;
      else op = 4'($urandom_range(OP_RELEASE, OP_NOT));
      li = (reach == 0) ? '0 : IDX_W'($urandom_range(reach - 1));
      ri = (reach == 0) ? '0 : IDX_W'($urandom_range(reach - 1));
      if ($urandom_range(99) < 6) begin
        case ($urandom_range(2))
          0:       op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
          1:       li = IDX_W'($urandom);
          default: ri = IDX_W'($urandom);
        endcase
      end
      case ($urandom_range(5))
        0:       atom = '1;
        1:       atom = '0;
        2:       atom = mask_t'(1) << $urandom_range(MASK_W - 1);
        default: atom = {$urandom, $urandom};
      endcase
      send_node(op, li, ri, atom, k == size - 1);
    end
  endtask

  initial begin
    int sent;
    int size;
    int mode;
    rst_n                 = 1'b0;
    cfg_valid             = 1'b0;
    cfg_index             = CFG_POSITIONS;
    cfg_data              = '0;
    send_idle             = 0;
    stall_pct             = 0;
    node_chan.valid       = 1'b0;
    node_chan.operation   = OP_ATOM;
    node_chan.left_index  = '0;
    node_chan.right_index = '0;
    node_chan.atom_bits   = '0;
    node_chan.last_node   = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_node(OP_ATOM, 6'd0, 6'd0, '1, 1'b0);
    send_node(OP_ATOM, 6'd0, 6'd0, '0, 1'b0);
    send_node(OP_ATOM, 6'd0, 6'd0, 64'h5555_5555_5555_5555, 1'b0);
    send_node(OP_ATOM, 6'd0, 6'd0, 64'h8000_0000_0000_0001, 1'b0);
    send_node(OP_NOT, 6'd2, 6'd0, '0, 1'b0);
    send_node(OP_AND, 6'd2, 6'd3, '0, 1'b0);
    send_node(OP_OR, 6'd1, 6'd3, '0, 1'b0);
    send_node(OP_IMPLIES, 6'd3, 6'd2, '0, 1'b0);
    send_node(OP_IFF, 6'd2, 6'd4, '0, 1'b0);
    send_node(OP_NEXT, 6'd3, 6'd0, '0, 1'b0);
    send_node(OP_EVENTUALLY, 6'd3, 6'd0, '0, 1'b0);
    send_node(OP_GLOBALLY, 6'd0, 6'd0, '0, 1'b0);
    send_node(OP_UNTIL, 6'd2, 6'd3, '0, 1'b0);
    send_node(OP_WEAK_UNTIL, 6'd2, 6'd1, '0, 1'b0);
    send_node(OP_RELEASE, 6'd3, 6'd2, '0, 1'b0);
    send_node(OP_SPARE_LO, 6'd63, 6'd63, '1, 1'b0);
    send_node(OP_SPARE_HI, 6'd0, 6'd0, '1, 1'b0);
    send_node(OP_AND, 6'd63, 6'd0, '0, 1'b0);
    send_node(OP_NOT, 6'd18, 6'd0, '0, 1'b1);
    send_node(OP_NEXT, 6'd0, 6'd0, '0, 1'b0);
    send_node(OP_ATOM, 6'd0, 6'd0, '1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_POSITIONS, phase_pos[p]);
      write_reg(CFG_LOOP_BACK, {1'($urandom_range(1)), phase_loop[p]});
      mode      = p % 4;
      send_idle = idle_send[mode];
      stall_pct = idle_stall[mode];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        size = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(10, 1);
        send_formula(size);
        sent += size;
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
